[design/fbre_pkg.sv]
// Shared types and constants of the page framebuffer raster engine.
package fbre_pkg;

  // Opcodes of the command channel.
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_PIXEL = 3'd1;
  localparam logic [2:0] OP_RECT  = 3'd2;
  localparam logic [2:0] OP_LINE  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [7:0] WIDTH_RESET  = 8'd128;
  localparam logic [6:0] HEIGHT_RESET = 7'd64;

  // Row within an eight-row page.
  localparam logic [2:0] ROW_IN_PAGE = 3'h7;

  // Divider steps: one quotient bit per cycle over a 12-bit magnitude.
  localparam logic [3:0] DIV_STEPS = 4'd12;

  // Coordinates with room for rectangle overhang past 2047.
  typedef logic signed [12:0] coord_t;

  typedef struct packed {
    logic          done;
    logic signed [12:0] quot;
    logic [11:0]   rem;
  } div_res_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_DIV,
    S_CALC,
    S_RD,
    S_WR,
    S_STEP,
    S_RBCHK,
    S_RBRD,
    S_RBDAT,
    S_OUT
  } state_e;

endpackage

[design/fbre_store.sv]
// Framebuffer byte memory: one write port, one registered read port.
module fbre_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[design/fbre_div.sv]
// Iterative restoring divider with floor correction for line slopes.
module fbre_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  fbre_pkg::coord_t     dividend_i,
  input  logic [11:0]          divisor_i,
  output fbre_pkg::div_res_t   res_o
);
  import fbre_pkg::*;

  logic        busy_q, done_q, neg_q;
  logic [3:0]  cnt_q;
  logic [11:0] rem_q, quo_q, dvs_q;
  logic [12:0] rem_sh, sub;
  logic        fits;
  logic [12:0] mag_full;

  assign mag_full = dividend_i[12] ? 13'(-dividend_i) : 13'(dividend_i);
  assign rem_sh   = {rem_q, quo_q[11]};
  assign fits     = rem_sh >= {1'b0, dvs_q};
  assign sub      = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_STEPS;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= mag_full[11:0];
      dvs_q <= divisor_i;
      neg_q <= dividend_i[12];
    end else if (busy_q) begin
      rem_q <= fits ? sub[11:0] : rem_sh[11:0];
      quo_q <= {quo_q[10:0], fits};
    end
  end

  // Round toward minus infinity for negative dividends.
  always_comb begin
    res_o.done = done_q;
    if (neg_q && rem_q != '0) begin
      res_o.quot = -(13'(quo_q) + 13'sd1);
      res_o.rem  = dvs_q - rem_q;
    end else if (neg_q) begin
      res_o.quot = -13'(quo_q);
      res_o.rem  = rem_q;
    end else begin
      res_o.quot = 13'(quo_q);
      res_o.rem  = rem_q;
    end
  end

endmodule

[design/page_framebuffer_raster_engine.sv]
// Top level: page-mode monochrome framebuffer with a command sequencer.
//
// One request at a time. Pixel (x, y) lives in bit y%8 of byte x + W*(y/8).
// Every visible pixel is a read-modify-write of one framebuffer byte through
// the single memory port pair; a clipped one skips the read and the write.
// Rectangle: w*h pixels. Line: unless vertical, the divider first computes
// the slope (12 quotient bits), then one pixel per column (or per row when
// vertical). Clear: one byte per cycle over all MAX_WIDTH*MAX_PAGES bytes.
// Read byte: the index is checked against the panel, then the byte is read;
// an index out of range skips the read. After reset the same clearing pass
// runs before the first request is taken; configuration writes are taken at
// any time and should only be issued while idle. Each request returns
// exactly one result, held until the sink takes it.
module page_framebuffer_raster_engine #(
  parameter int MAX_WIDTH = 128,
  parameter int MAX_PAGES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic signed [11:0] x_a_i,
  input  logic signed [11:0] y_a_i,
  input  logic signed [11:0] x_b_i,
  input  logic signed [11:0] y_b_i,
  input  logic [7:0]  rect_width_i,
  input  logic [7:0]  rect_height_i,
  input  logic        inverse_i,
  input  logic [9:0]  byte_index_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        index_error_o
);
  import fbre_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_PAGES;
  localparam int AW    = $clog2(DEPTH);

  state_e state_q, state_d;

  logic [7:0]  pw_q;
  logic [6:0]  ph_q;

  // effective panel size
  logic [8:0]  w_eff;
  logic [7:0]  h_eff;
  logic [4:0]  pages;
  logic [13:0] limit;

  assign w_eff = ({1'b0, pw_q} < 9'(MAX_WIDTH)) ? {1'b0, pw_q} : 9'(MAX_WIDTH);
  assign h_eff = ({1'b0, ph_q[6:3], 3'b000} < 8'(MAX_PAGES * 8)) ?
                 {1'b0, ph_q[6:3], 3'b000} : 8'(MAX_PAGES * 8);
  assign pages = h_eff[7:3];
  assign limit = 14'(w_eff) * 14'(pages);

  // request registers
  logic [2:0]  op_q;
  logic        inv_q, vert_q;
  coord_t      px_q, py_q, y1_q, end_q;
  logic [7:0]  ci_q, cj_q, rw_q, rh_q;
  logic [11:0] dx_q, rd_q, r_q;
  coord_t      qd_q;
  logic [AW-1:0] idx_q, sweep_q;
  logic [2:0]  bit_q;
  logic [9:0]  bidx_q;
  logic [7:0]  rdata_q;
  logic        err_q;

  logic        accept, last, visible, sweep_done;
  logic        div_start;
  div_res_t    div_res;
  logic [7:0]  mem_rdata, mem_wdata, mask;
  logic [AW-1:0] mem_raddr, mem_waddr, idx_c;
  logic        mem_we;
  logic [12:0] prod;

  // line endpoints after the left-to-right swap
  coord_t lx1, ly1, lx2, ly2, ldy;
  logic   swap;

  assign accept = in_valid_i && !in_stall_o;
  assign swap   = x_a_i > x_b_i;
  assign lx1    = swap ? 13'(x_b_i) : 13'(x_a_i);
  assign ly1    = swap ? 13'(y_b_i) : 13'(y_a_i);
  assign lx2    = swap ? 13'(x_a_i) : 13'(x_b_i);
  assign ly2    = swap ? 13'(y_a_i) : 13'(y_b_i);
  assign ldy    = ly2 - ly1;
  assign div_start = accept && op_i == OP_LINE && lx1 != lx2;

  fbre_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ldy),
    .divisor_i  (12'(lx2 - lx1)),
    .res_o      (div_res)
  );

  // clipping and byte address of the current pixel
  assign visible = !px_q[12] && (px_q[11:0] < 12'(w_eff)) &&
                   !py_q[12] && (py_q[11:0] < 12'(h_eff));
  assign prod    = 13'(w_eff) * 13'(py_q[6:3]);
  assign idx_c   = AW'(prod + 13'(px_q[8:0]));
  assign mask    = 8'd1 << bit_q;
  assign sweep_done = sweep_q == AW'(DEPTH - 1);

  // Line step: accumulate the slope remainder, carry into y when it wraps.
  logic [12:0] r_sum;
  logic        r_wrap;
  assign r_sum  = {1'b0, r_q} + {1'b0, rd_q};
  assign r_wrap = r_sum >= {1'b0, dx_q};

  // last pixel of the current command
  always_comb begin
    unique case (op_q)
      OP_RECT: last = (ci_q == rw_q - 8'd1) && (cj_q == rh_q - 8'd1);
      OP_LINE: last = vert_q ? (py_q == end_q) : (px_q == end_q);
      default: last = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT, S_CLR: if (sweep_done) state_d = (state_q == S_INIT) ? S_IDLE : S_OUT;
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            OP_CLEAR: state_d = S_CLR;
            OP_PIXEL: state_d = S_CALC;
            OP_RECT:  state_d = (rect_width_i == '0 || rect_height_i == '0) ? S_OUT : S_CALC;
            OP_LINE:  state_d = (lx1 != lx2) ? S_DIV : S_CALC;
            OP_READ:  state_d = S_RBCHK;
            default:  state_d = S_OUT;
          endcase
        end
      end
      S_DIV:   if (div_res.done) state_d = S_CALC;
      S_CALC:  state_d = visible ? S_RD : S_STEP;
      S_RD:    state_d = S_WR;
      S_WR:    state_d = S_STEP;
      S_STEP:  state_d = last ? S_OUT : S_CALC;
      S_RBCHK: state_d = ({4'b0, bidx_q} >= limit) ? S_OUT : S_RBRD;
      S_RBRD:  state_d = S_RBDAT;
      S_RBDAT: state_d = S_OUT;
      S_OUT:   if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and memory port control
  always_comb begin
    in_stall_o = state_q != S_IDLE;
    out_valid_o = state_q == S_OUT;
    mem_raddr = (state_q == S_RBRD) ? AW'(bidx_q) : idx_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = inv_q ? (mem_rdata & ~mask) : (mem_rdata | mask);
    unique case (state_q)
      S_INIT, S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
      end
      S_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  assign read_data_o   = rdata_q;
  assign index_error_o = err_q;

  fbre_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      pw_q    <= WIDTH_RESET;
      ph_q    <= HEIGHT_RESET;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_WIDTH:  pw_q <= cfg_data_i;
          REG_HEIGHT: ph_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (state_q == S_INIT || state_q == S_CLR) begin
        sweep_q <= sweep_done ? '0 : sweep_q + AW'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_q    <= op_i;
          inv_q   <= (op_i == OP_LINE) ? 1'b0 : inverse_i;
          rw_q    <= rect_width_i;
          rh_q    <= rect_height_i;
          bidx_q  <= byte_index_i;
          ci_q    <= '0;
          cj_q    <= '0;
          rdata_q <= '0;
          err_q   <= 1'b0;
          y1_q    <= 13'(y_a_i);
          vert_q  <= lx1 == lx2;
          r_q     <= '0;
          dx_q    <= 12'(lx2 - lx1);
          if (op_i == OP_LINE) begin
            px_q <= lx1;
            if (lx1 == lx2) begin
              py_q  <= (ly1 > ly2) ? ly2 : ly1;
              end_q <= (ly1 > ly2) ? ly1 : ly2;
            end else begin
              py_q  <= ly1;
              end_q <= lx2;
            end
          end else begin
            px_q <= 13'(x_a_i);
            py_q <= 13'(y_a_i);
          end
        end
      end
      S_DIV: begin
        qd_q <= div_res.quot;
        rd_q <= div_res.rem;
      end
      S_CALC: begin
        idx_q <= idx_c;
        bit_q <= py_q[2:0] & ROW_IN_PAGE;
      end
      S_STEP: begin
        if (op_q == OP_RECT) begin
          if (cj_q == rh_q - 8'd1) begin
            cj_q <= '0;
            py_q <= y1_q;
            ci_q <= ci_q + 8'd1;
            px_q <= px_q + 13'sd1;
          end else begin
            cj_q <= cj_q + 8'd1;
            py_q <= py_q + 13'sd1;
          end
        end else if (vert_q) begin
          py_q <= py_q + 13'sd1;
        end else begin
          px_q <= px_q + 13'sd1;
          py_q <= py_q + qd_q + (r_wrap ? 13'sd1 : 13'sd0);
          r_q  <= r_wrap ? 12'(r_sum - {1'b0, dx_q}) : r_sum[11:0];
        end
      end
      S_RBCHK: err_q <= {4'b0, bidx_q} >= limit;
      S_RBDAT: rdata_q <= mem_rdata;
      default: ;
    endcase
  end

endmodule

[sim/fbre_checker.sv]
// Checker: watches both channels, keeps a shadow framebuffer, compares results.
module fbre_checker #(
  parameter int MAX_WIDTH = 128,
  parameter int MAX_PAGES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [2:0]        op_i,
  input  logic signed [11:0] x_a_i,
  input  logic signed [11:0] y_a_i,
  input  logic signed [11:0] x_b_i,
  input  logic signed [11:0] y_b_i,
  input  logic [7:0]        rect_width_i,
  input  logic [7:0]        rect_height_i,
  input  logic              inverse_i,
  input  logic [9:0]        byte_index_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [7:0]        read_data_i,
  input  logic              index_error_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fbre_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
  } fb_result_t;

  logic [7:0] shadow_fb [MAX_WIDTH*MAX_PAGES];
  logic [7:0] shadow_width;
  logic [6:0] shadow_height;
  fb_result_t expected_results[$];

  function automatic int vis_width();
    return (shadow_width < MAX_WIDTH) ? int'(shadow_width) : MAX_WIDTH;
  endfunction

  function automatic int vis_height();
    int h;
    h = int'(shadow_height) & ~7;
    return (h < MAX_PAGES * 8) ? h : MAX_PAGES * 8;
  endfunction

  task automatic put_pixel(input int x, input int y, input logic erase);
    int idx;
    if (x < 0 || y < 0 || x >= vis_width() || y >= vis_height()) return;
    idx = x + vis_width() * (y >> 3);
    if (idx >= MAX_WIDTH * MAX_PAGES) return;
    if (erase) shadow_fb[idx][y & 7] = 1'b0;
    else shadow_fb[idx][y & 7] = 1'b1;
  endtask

  // floor division, d > 0
  function automatic int div_floor(input int n, input int d);
    int q;
    q = n / d;
    if (n < 0 && q * d != n) q--;
    return q;
  endfunction

  task automatic draw_segment(input int x1, input int y1, input int x2, input int y2);
    int t, dx, dy;
    if (x1 > x2) begin
      t = x1; x1 = x2; x2 = t;
      t = y1; y1 = y2; y2 = t;
    end
    if (x1 == x2) begin
      if (y1 > y2) begin
        t = y1; y1 = y2; y2 = t;
      end
      for (int k = y1; k <= y2; k++) put_pixel(x1, k, 1'b0);
      return;
    end
    dx = x2 - x1;
    dy = y2 - y1;
    for (int k = 0; k <= dx; k++) put_pixel(x1 + k, y1 + div_floor(dy * k, dx), 1'b0);
  endtask

  task automatic apply_request();
    fb_result_t r;
    int lim;
    r = '0;
    case (op_i)
      OP_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      OP_PIXEL: put_pixel(int'(x_a_i), int'(y_a_i), inverse_i);
      OP_RECT: begin
        for (int i = 0; i < int'(rect_width_i); i++)
          for (int j = 0; j < int'(rect_height_i); j++)
            put_pixel(int'(x_a_i) + i, int'(y_a_i) + j, inverse_i);
      end
      OP_LINE: draw_segment(int'(x_a_i), int'(y_a_i), int'(x_b_i), int'(y_b_i));
      OP_READ: begin
        lim = vis_width() * (vis_height() >> 3);
        if (int'(byte_index_i) < lim) r.data = shadow_fb[byte_index_i];
        else r.err = 1'b1;
      end
      default: ;
    endcase
    expected_results.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fb_result_t e;
    if (!rst_ni) begin
      foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      shadow_width = WIDTH_RESET;
      shadow_height = HEIGHT_RESET;
      expected_results.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_WIDTH) shadow_width = cfg_data_i;
        else shadow_height = cfg_data_i[6:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result data=%h err=%b", $time, read_data_i,
                   index_error_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_results.pop_front();
          if (read_data_i !== e.data || index_error_i !== e.err) begin
            $display("%0t: mismatch expected data=%h err=%b actual data=%h err=%b",
                     $time, e.data, e.err, read_data_i, index_error_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_request();
    end
    pending_o <= expected_results.size();
  end
endmodule

[sim/page_framebuffer_raster_engine_tb.sv]
// Testbench top: request stimulus, config phases, idling and the verdict.
module page_framebuffer_raster_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbre_pkg::*;

  // longest request: 255x255 rectangle, with margin
  localparam int WATCHDOG_LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [7:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] op_i = '0;
  logic signed [11:0] x_a_i = '0, y_a_i = '0, x_b_i = '0, y_b_i = '0;
  logic [7:0] rect_width_i = '0, rect_height_i = '0;
  logic inverse_i = 1'b0;
  logic [9:0] byte_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [7:0] read_data_o;
  logic index_error_o;
  int fail_count, pending;
  int idle_cycles;
  bit stim_done = 1'b0;

  always #5 clk_i = ~clk_i;

  page_framebuffer_raster_engine dut (.*);

  fbre_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .op_i, .x_a_i, .y_a_i, .x_b_i, .y_b_i,
    .rect_width_i, .rect_height_i, .inverse_i, .byte_index_i,
    .out_valid_i(out_valid_o), .out_stall_i, .read_data_i(read_data_o),
    .index_error_i(index_error_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: cycles with no handshake on either channel. Also ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result sink: random stall per request; some stretches with none.
  initial begin
    int gap;
    bit burst;
    @(posedge rst_ni);
    forever begin
      burst = ($urandom_range(0, 5) == 0);
      repeat (20) begin
        gap = burst ? 0 : $urandom_range(0, 14);
        repeat (gap) @(negedge clk_i);
        out_stall_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
    end
  end

  // Per-request gap draw; one burst phase without gaps.
  bit no_gaps = 1'b0;

  task automatic send_request(input logic [2:0] op, input int xa, input int ya,
                              input int xb, input int yb, input int rw, input int rh,
                              input logic inv, input int bidx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    repeat (gap) @(negedge clk_i);
    op_i <= op;
    x_a_i <= xa[11:0];
    y_a_i <= ya[11:0];
    x_b_i <= xb[11:0];
    y_b_i <= yb[11:0];
    rect_width_i <= rw[7:0];
    rect_height_i <= rh[7:0];
    inverse_i <= inv;
    byte_index_i <= bidx[9:0];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait until all results are back, then let the engine settle before config.
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_panel(input int w, input int h);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_WIDTH;
    cfg_data_i <= w[7:0];
    @(negedge clk_i);
    cfg_index_i <= REG_HEIGHT;
    cfg_data_i <= h[7:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int rnd_coord();
    // mostly on or near the panel, sometimes anywhere in 12 bits
    case ($urandom_range(0, 9))
      0: return int'($signed(12'($urandom())));
      1: return $urandom_range(0, 20) - 20;
      default: return $urandom_range(0, 140);
    endcase
  endfunction

  task automatic random_request();
    int sel, rw, rh;
    logic [2:0] op;
    sel = $urandom_range(0, 99);
    if (sel < 2) op = OP_CLEAR;
    else if (sel < 30) op = OP_PIXEL;
    else if (sel < 45) op = OP_RECT;
    else if (sel < 65) op = OP_LINE;
    else if (sel < 97) op = OP_READ;
    else op = 3'($urandom_range(5, 7));
    // mostly small rectangles, a rare large one
    rw = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
    rh = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
    if (op == OP_LINE && $urandom_range(0, 3) == 0) begin
      // short line keeps slow cases rare
      send_request(op, $urandom_range(0, 130), $urandom_range(0, 70),
                   $urandom_range(0, 130), $urandom_range(0, 70), rw, rh,
                   1'($urandom()), $urandom_range(0, 1023));
    end else begin
      send_request(op, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rw, rh,
                   1'($urandom()), $urandom_range(0, 1023));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, every opcode, special cases
    send_request(OP_PIXEL, 0, 0, 0, 0, 0, 0, 1'b0, 0);
    send_request(OP_PIXEL, 127, 63, 0, 0, 0, 0, 1'b0, 0);
    send_request(OP_PIXEL, -2048, 2047, 0, 0, 0, 0, 1'b0, 0);
    send_request(OP_PIXEL, 2047, -1, 0, 0, 0, 0, 1'b0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0, 0, 1'b0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0, 0, 1'b0, 1023);
    send_request(OP_READ, 0, 0, 0, 0, 0, 0, 1'b0, 1023 - 128 + 127);
    send_request(OP_RECT, -3, -3, 0, 0, 10, 12, 1'b0, 0);
    send_request(OP_RECT, 120, 60, 0, 0, 255, 255, 1'b0, 0);
    send_request(OP_RECT, 5, 5, 0, 0, 0, 7, 1'b0, 0);
    send_request(OP_RECT, 2, 1, 0, 0, 4, 3, 1'b1, 0);
    send_request(OP_LINE, 100, 2, 10, 50, 0, 0, 1'b1, 0);
    send_request(OP_LINE, 30, 60, 30, -5, 0, 0, 1'b0, 0);
    send_request(OP_LINE, -2048, -2048, 2047, 2047, 0, 0, 1'b0, 0);
    send_request(OP_LINE, 0, 63, 127, 0, 0, 0, 1'b0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0, 0, 1'b0, 130);
    send_request(3'd5, 1, 1, 1, 1, 1, 1, 1'b1, 1);
    send_request(3'd7, 0, 0, 0, 0, 0, 0, 1'b0, 0);
    send_request(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0, 0, 1'b0, 130);
    // panel sizes: empty, odd, extremes, oversize
    set_panel(0, 64);
    send_request(OP_PIXEL, 0, 0, 0, 0, 0, 0, 1'b0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0, 0, 1'b0, 0);
    set_panel(1, 8);
    for (int n = 0; n < 60; n++) random_request();
    set_panel(255, 127);
    for (int n = 0; n < 150; n++) random_request();
    set_panel(37, 23);
    for (int n = 0; n < 150; n++) random_request();
    set_panel(96, 0);
    for (int n = 0; n < 30; n++) random_request();
    set_panel(128, 64);
    no_gaps = 1'b1;
    for (int n = 0; n < 150; n++) random_request();
    no_gaps = 1'b0;
    set_panel(64, 32);
    for (int n = 0; n < 150; n++) random_request();
    set_panel(128, 64);
    for (int n = 0; n < 150; n++) random_request();
    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
